### design/logical_volume_segment_remapper_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the logical volume segment remapper
// Implication checks used by the remapper modules; compiled out when
// NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef LOGICAL_VOLUME_SEGMENT_REMAPPER_MACROS_SVH
`define LOGICAL_VOLUME_SEGMENT_REMAPPER_MACROS_SVH

`ifndef NO_ASSERTIONS
`define LVSR_ASSERT_IMP(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("lvsr: same-cycle check failed");
`define LVSR_ASSERT_NXT(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("lvsr: next-cycle check failed");
`else
`define LVSR_ASSERT_IMP(label, ck, rs, ante, cons)
`define LVSR_ASSERT_NXT(label, ck, rs, ante, cons)
`endif

`endif

### design/lvsr_pkg.sv
// ----------------------------------------------------------------------------
// Remapper package
// Result status codes, fixed field widths and the item classification type.
// ----------------------------------------------------------------------------
package lvsr_pkg;

  localparam int STATUS_W = 3;
  localparam int VOL_W    = 4;
  localparam int CFG_W    = 5;

  localparam logic [STATUS_W-1:0] STATUS_RUN       = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_ADDED     = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_NO_SEG    = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_BAD_VOL   = 3'd4;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 3'd5;
  localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 3'd6;

  typedef struct packed {
    logic is_request;
    logic no_sectors;
  } lvsr_class_t;

endpackage

### design/lvsr_front.sv
// ----------------------------------------------------------------------------
// Remapper front end
// Accepts transactions, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module lvsr_front #(
  parameter int SECTOR_BITS = 48
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      kind,
  input  logic [SECTOR_BITS-1:0]    logical_start,
  input  logic [SECTOR_BITS-1:0]    sector_total,
  input  logic [lvsr_pkg::VOL_W-1:0] volume_index,
  input  logic [SECTOR_BITS-1:0]    volume_start,
  output logic                      q_valid,
  input  logic                      q_ready,
  output lvsr_pkg::lvsr_class_t     q_class,
  output logic [SECTOR_BITS-1:0]    q_start,
  output logic [SECTOR_BITS-1:0]    q_total,
  output logic [lvsr_pkg::VOL_W-1:0] q_volume,
  output logic [SECTOR_BITS-1:0]    q_vstart
);
  import lvsr_pkg::*;

  lvsr_class_t            ent_class  [2];
  logic [SECTOR_BITS-1:0] ent_start  [2];
  logic [SECTOR_BITS-1:0] ent_total  [2];
  logic [VOL_W-1:0]       ent_volume [2];
  logic [SECTOR_BITS-1:0] ent_vstart [2];
  logic                   wr_ptr;
  logic                   rd_ptr;
  logic [1:0]             count;
  logic                   push;
  logic                   pop;
  lvsr_class_t            in_class;

  assign in_ready = (count != 2'd2);
  assign q_valid  = (count != 2'd0);
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_comb begin
    in_class.is_request = kind;
    in_class.no_sectors = (sector_total == '0);
  end

  assign q_class  = ent_class[rd_ptr];
  assign q_start  = ent_start[rd_ptr];
  assign q_total  = ent_total[rd_ptr];
  assign q_volume = ent_volume[rd_ptr];
  assign q_vstart = ent_vstart[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      ent_class[wr_ptr]  <= in_class;
      ent_start[wr_ptr]  <= logical_start;
      ent_total[wr_ptr]  <= sector_total;
      ent_volume[wr_ptr] <= volume_index;
      ent_vstart[wr_ptr] <= volume_start;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      if (push && !pop)      count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

endmodule

### design/lvsr_back.sv
// ----------------------------------------------------------------------------
// Remapper back end
// Holds the segment table, carries out adds and walks requests run by run.
// ----------------------------------------------------------------------------
`include "logical_volume_segment_remapper_macros.svh"

module lvsr_back #(
  parameter int MAX_SEGMENTS = 32,
  parameter int MAX_VOLUMES  = 16,
  parameter int SECTOR_BITS  = 48
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [lvsr_pkg::CFG_W-1:0]   cfg_wdata,
  input  logic                         q_valid,
  output logic                         q_ready,
  input  lvsr_pkg::lvsr_class_t        q_class,
  input  logic [SECTOR_BITS-1:0]       q_start,
  input  logic [SECTOR_BITS-1:0]       q_total,
  input  logic [lvsr_pkg::VOL_W-1:0]   q_volume,
  input  logic [SECTOR_BITS-1:0]       q_vstart,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [lvsr_pkg::STATUS_W-1:0] status,
  output logic [lvsr_pkg::VOL_W-1:0]   run_volume,
  output logic [SECTOR_BITS-1:0]       run_sector,
  output logic [SECTOR_BITS-1:0]       run_length,
  output logic [SECTOR_BITS-1:0]       run_offset,
  output logic [SECTOR_BITS-1:0]       volume_size,
  output logic                         last
);
  import lvsr_pkg::*;

  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_ADD  = 3'd1;
  localparam logic [2:0] ST_LOOK = 3'd2;
  localparam logic [2:0] ST_PICK = 3'd3;
  localparam logic [2:0] ST_CALC = 3'd4;
  localparam logic [2:0] ST_EMIT = 3'd5;
  localparam logic [2:0] ST_END  = 3'd6;

  logic [SECTOR_BITS-1:0] tbl_start  [MAX_SEGMENTS];
  logic [SECTOR_BITS-1:0] tbl_end    [MAX_SEGMENTS];
  logic [VOL_W-1:0]       tbl_vol    [MAX_SEGMENTS];
  logic [SECTOR_BITS-1:0] tbl_vstart [MAX_SEGMENTS];

  logic [2:0]             state;
  logic [CW-1:0]          seg_count;
  logic [SECTOR_BITS-1:0] size;
  logic [CFG_W-1:0]       volume_count;

  logic [SECTOR_BITS-1:0] cur_start;
  logic [SECTOR_BITS-1:0] cur_total;
  logic [VOL_W-1:0]       cur_volume;
  logic [SECTOR_BITS-1:0] cur_vstart;
  logic [SECTOR_BITS-1:0] done;
  logic [SECTOR_BITS:0]   pos;
  logic [CW-1:0]          runs;
  logic [MAX_SEGMENTS-1:0] hit;
  logic [IW-1:0]          sel_idx;
  logic [SECTOR_BITS-1:0] avail;
  logic [SECTOR_BITS-1:0] rel;
  logic [SECTOR_BITS-1:0] remain;
  logic [STATUS_W-1:0]    end_code;

  logic                   out_free;
  logic                   issue;
  logic [MAX_SEGMENTS-1:0] hit_next;
  logic [IW-1:0]          pick_idx;
  logic                   pick_found;
  logic [CFG_W-1:0]       vols;
  logic [SECTOR_BITS:0]   add_end;
  logic                   add_full;
  logic                   add_ok;
  logic [SECTOR_BITS-1:0] size_next;
  logic [SECTOR_BITS-1:0] len;
  logic                   run_fin;

  assign out_free = !out_valid || out_ready;
  assign q_ready  = (state == ST_IDLE);
  assign issue    = out_free &&
                    (state == ST_ADD || state == ST_EMIT || state == ST_END);

  // Every held segment is compared against the current position at once.
  always_comb begin
    for (int i = 0; i < MAX_SEGMENTS; i++) begin
      hit_next[i] = (CW'(i) < seg_count) &&
                    (pos >= {1'b0, tbl_start[i]}) && (pos < {1'b0, tbl_end[i]});
    end
  end

  // The lowest matching entry wins.
  always_comb begin
    pick_idx   = '0;
    pick_found = 1'b0;
    for (int i = MAX_SEGMENTS - 1; i >= 0; i--) begin
      if (hit[i]) begin
        pick_idx   = IW'(i);
        pick_found = 1'b1;
      end
    end
  end

  assign vols = (volume_count < CFG_W'(MAX_VOLUMES)) ? volume_count : CFG_W'(MAX_VOLUMES);

  assign add_end   = {1'b0, cur_start} + {1'b0, cur_total};
  assign add_full  = (seg_count >= CW'(MAX_SEGMENTS));
  assign add_ok    = !add_full && !add_end[SECTOR_BITS];
  assign size_next = (add_ok && (add_end[SECTOR_BITS-1:0] > size)) ?
                     add_end[SECTOR_BITS-1:0] : size;

  assign len     = (remain <= avail) ? remain : avail;
  assign run_fin = (remain <= avail) || (runs == CW'(MAX_SEGMENTS - 1));

  always_ff @(posedge clk) begin
    if (state == ST_ADD && out_free && add_ok) begin
      tbl_start[seg_count[IW-1:0]]  <= cur_start;
      tbl_end[seg_count[IW-1:0]]    <= add_end[SECTOR_BITS-1:0];
      tbl_vol[seg_count[IW-1:0]]    <= cur_volume;
      tbl_vstart[seg_count[IW-1:0]] <= cur_vstart;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      seg_count    <= '0;
      size         <= '0;
      volume_count <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) volume_count <= cfg_wdata;
      if (issue) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;

      case (state)
        ST_IDLE: begin
          if (q_valid) begin
            cur_start  <= q_start;
            cur_total  <= q_total;
            cur_volume <= q_volume;
            cur_vstart <= q_vstart;
            done       <= '0;
            runs       <= '0;
            pos        <= {1'b0, q_start};
            if (!q_class.is_request) begin
              state <= ST_ADD;
            end else if (q_class.no_sectors) begin
              end_code <= STATUS_EMPTY;
              state    <= ST_END;
            end else begin
              state <= ST_LOOK;
            end
          end
        end
        ST_ADD: begin
          if (out_free) begin
            if (add_ok) seg_count <= seg_count + CW'(1);
            size        <= size_next;
            status      <= add_full ? STATUS_FULL :
                           (add_ok ? STATUS_ADDED : STATUS_OVERFLOW);
            run_volume  <= '0;
            run_sector  <= '0;
            run_length  <= '0;
            run_offset  <= '0;
            volume_size <= size_next;
            last        <= 1'b1;
            state       <= ST_IDLE;
          end
        end
        ST_LOOK: begin
          hit   <= hit_next;
          state <= ST_PICK;
        end
        ST_PICK: begin
          sel_idx <= pick_idx;
          if (pick_found) begin
            state <= ST_CALC;
          end else begin
            end_code <= STATUS_NO_SEG;
            state    <= ST_END;
          end
        end
        ST_CALC: begin
          if ({1'b0, tbl_vol[sel_idx]} >= vols) begin
            end_code <= STATUS_BAD_VOL;
            state    <= ST_END;
          end else begin
            // The matched entry holds pos, so pos fits in the sector width here.
            avail  <= tbl_end[sel_idx] - pos[SECTOR_BITS-1:0];
            rel    <= pos[SECTOR_BITS-1:0] - tbl_start[sel_idx];
            remain <= cur_total - done;
            state  <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            status      <= STATUS_RUN;
            run_volume  <= tbl_vol[sel_idx];
            run_sector  <= tbl_vstart[sel_idx] + rel;
            run_length  <= len;
            run_offset  <= done;
            volume_size <= size;
            last        <= run_fin;
            done        <= done + len;
            pos         <= pos + {1'b0, len};
            runs        <= runs + CW'(1);
            state       <= run_fin ? ST_IDLE : ST_LOOK;
          end
        end
        ST_END: begin
          if (out_free) begin
            status      <= end_code;
            run_volume  <= '0;
            run_sector  <= '0;
            run_length  <= '0;
            run_offset  <= done;
            volume_size <= size;
            last        <= 1'b1;
            state       <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `LVSR_ASSERT_IMP(a_count_bound, clk, rst, 1'b1, seg_count <= CW'(MAX_SEGMENTS))
  `LVSR_ASSERT_IMP(a_run_nonzero, clk, rst, out_valid && status == STATUS_RUN, run_length != '0)
  `LVSR_ASSERT_NXT(a_gap_ends, clk, rst, state == ST_PICK && hit == '0, state == ST_END)
  `LVSR_ASSERT_IMP(a_add_last, clk, rst, out_valid && status == STATUS_ADDED, last && run_offset == '0)

endmodule

### design/logical_volume_segment_remapper.sv
// ----------------------------------------------------------------------------
// Logical volume segment remapper
// Maps logical sector requests onto physical volume runs through a segment table.
// ----------------------------------------------------------------------------
// An add transaction leaves the queue head in the idle state and gives its
// result from the add state. A request leaves the queue in the idle state and
// then steps through the lookup sequence of the back end for each run (compare
// against every segment, pick the first match, read the entry, issue); a gap
// ends it from the pick step and a bad volume from the read step, each through
// the end state. A two-entry queue lets new transactions be taken while the
// back end works, and the result register lets a finished result wait. The
// segment table needs no clearing after reset.
module logical_volume_segment_remapper #(
  parameter int MAX_SEGMENTS = 32,
  parameter int MAX_VOLUMES  = 16,
  parameter int SECTOR_BITS  = 48
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [lvsr_pkg::CFG_W-1:0]    cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          kind,
  input  logic [SECTOR_BITS-1:0]        logical_start,
  input  logic [SECTOR_BITS-1:0]        sector_total,
  input  logic [lvsr_pkg::VOL_W-1:0]    volume_index,
  input  logic [SECTOR_BITS-1:0]        volume_start,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [lvsr_pkg::STATUS_W-1:0] status,
  output logic [lvsr_pkg::VOL_W-1:0]    run_volume,
  output logic [SECTOR_BITS-1:0]        run_sector,
  output logic [SECTOR_BITS-1:0]        run_length,
  output logic [SECTOR_BITS-1:0]        run_offset,
  output logic [SECTOR_BITS-1:0]        volume_size,
  output logic                          last
);
  import lvsr_pkg::*;

  logic                   q_valid;
  logic                   q_ready;
  lvsr_class_t            q_class;
  logic [SECTOR_BITS-1:0] q_start;
  logic [SECTOR_BITS-1:0] q_total;
  logic [VOL_W-1:0]       q_volume;
  logic [SECTOR_BITS-1:0] q_vstart;

  lvsr_front #(
    .SECTOR_BITS (SECTOR_BITS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .kind          (kind),
    .logical_start (logical_start),
    .sector_total  (sector_total),
    .volume_index  (volume_index),
    .volume_start  (volume_start),
    .q_valid       (q_valid),
    .q_ready       (q_ready),
    .q_class       (q_class),
    .q_start       (q_start),
    .q_total       (q_total),
    .q_volume      (q_volume),
    .q_vstart      (q_vstart)
  );

  lvsr_back #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .MAX_VOLUMES  (MAX_VOLUMES),
    .SECTOR_BITS  (SECTOR_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .q_valid     (q_valid),
    .q_ready     (q_ready),
    .q_class     (q_class),
    .q_start     (q_start),
    .q_total     (q_total),
    .q_volume    (q_volume),
    .q_vstart    (q_vstart),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .run_volume  (run_volume),
    .run_sector  (run_sector),
    .run_length  (run_length),
    .run_offset  (run_offset),
    .volume_size (volume_size),
    .last        (last)
  );

endmodule

### bench/tb.sv
// ----------------------------------------------------------------------------
// Segment remapper testbench
// Drives segment adds and sector requests through the valid/ready ports and
// checks every result against an in-bench model of the segment table.
// ----------------------------------------------------------------------------
module tb;
  import lvsr_pkg::*;

  localparam int NSEG = 32;
  localparam int NVOL = 16;
  localparam logic [48:0] SECT_LIMIT = 49'h0_FFFF_FFFF_FFFF;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic        kind;
    logic [47:0] lstart;
    logic [47:0] total;
    logic [3:0]  vol;
    logic [47:0] vstart;
  } xact_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  vol;
    logic [47:0] sector;
    logic [47:0] length;
    logic [47:0] offset;
    logic [47:0] size;
    logic        last;
  } run_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic kind = 1'b0;
  logic [47:0] logical_start = '0, sector_total = '0, volume_start = '0;
  logic [3:0] volume_index = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [2:0] status;
  logic [3:0] run_volume;
  logic [47:0] run_sector, run_length, run_offset, volume_size;
  logic last;

  logical_volume_segment_remapper u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .kind(kind),
    .logical_start(logical_start), .sector_total(sector_total),
    .volume_index(volume_index), .volume_start(volume_start),
    .out_valid(out_valid), .out_ready(out_ready), .status(status),
    .run_volume(run_volume), .run_sector(run_sector), .run_length(run_length),
    .run_offset(run_offset), .volume_size(volume_size), .last(last)
  );

  // Model of the segment table.
  logic [47:0] tbl_start [NSEG];
  logic [47:0] tbl_end [NSEG];
  logic [3:0]  tbl_vol [NSEG];
  logic [47:0] tbl_pstart [NSEG];
  int          tbl_count = 0;
  logic [47:0] vol_size = '0;
  logic [4:0]  attached = '0;

  xact_t pending[$];
  run_t  expected_runs[$];
  int    mismatches = 0;
  int    cycles = 0;
  bit    rx_quiet = 1'b0;
  bit    accepted_flag = 1'b0;
  bit    tx_nogap = 1'b0;
  bit    hold_start = 1'b0;
  int    hold_cnt = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic run_t mk(logic [2:0] st, logic [3:0] v, logic [47:0] s,
                              logic [47:0] l, logic [47:0] o, logic lst);
    run_t r;
    r.status = st; r.vol = v; r.sector = s; r.length = l; r.offset = o;
    r.size = vol_size; r.last = lst;
    return r;
  endfunction

  function automatic void add_expected(run_t r);
    expected_runs.insert(expected_runs.size(), r);
  endfunction

  function automatic void queue_item(xact_t x);
    pending.insert(pending.size(), x);
  endfunction

  function automatic int lookup_segment(logic [47:0] sec);
    for (int i = 0; i < tbl_count; i++)
      if (sec >= tbl_start[i] && sec < tbl_end[i]) return i;
    return -1;
  endfunction

  // Works out the results of one transaction and advances the table.
  task automatic remap_item(xact_t x);
    logic [48:0] seg_end;
    logic [47:0] done, pos, avail, len;
    int n, s, vols;
    run_t r;
    done = '0;
    n = 0;
    vols = (attached < NVOL) ? attached : NVOL;
    if (!x.kind) begin
      seg_end = {1'b0, x.lstart} + {1'b0, x.total};
      if (tbl_count >= NSEG) begin
        add_expected(mk(STATUS_FULL, '0, '0, '0, '0, 1'b1));
      end else if (seg_end > SECT_LIMIT) begin
        add_expected(mk(STATUS_OVERFLOW, '0, '0, '0, '0, 1'b1));
      end else begin
        tbl_start[tbl_count] = x.lstart;
        tbl_end[tbl_count] = seg_end[47:0];
        tbl_vol[tbl_count] = x.vol;
        tbl_pstart[tbl_count] = x.vstart;
        tbl_count++;
        if (seg_end[47:0] > vol_size) vol_size = seg_end[47:0];
        add_expected(mk(STATUS_ADDED, '0, '0, '0, '0, 1'b1));
      end
      return;
    end
    if (x.total == 0) begin
      add_expected(mk(STATUS_EMPTY, '0, '0, '0, '0, 1'b1));
      return;
    end
    while (done < x.total && n < NSEG) begin
      pos = x.lstart + done;
      s = lookup_segment(pos);
      if (s < 0) begin
        add_expected(mk(STATUS_NO_SEG, '0, '0, '0, done, 1'b1));
        return;
      end
      if (tbl_vol[s] >= vols) begin
        add_expected(mk(STATUS_BAD_VOL, '0, '0, '0, done, 1'b1));
        return;
      end
      avail = tbl_end[s] - pos;
      len = x.total - done;
      if (len > avail) len = avail;
      add_expected(mk(STATUS_RUN, tbl_vol[s],
                      tbl_pstart[s] + (pos - tbl_start[s]), len, done, 1'b0));
      n++;
      done += len;
    end
    r = expected_runs.pop_back();
    r.last = 1'b1;
    add_expected(r);
  endtask

  // Driver: presents queued transactions, with random idle cycles.
  always @(negedge clk) begin
    if (!rst) begin
      if (!in_valid || accepted_flag) begin
        if (pending.size() > 0 && (tx_nogap || $urandom_range(99) >= 26)) begin
          xact_t x;
          x = pending.pop_front();
          remap_item(x);
          kind <= x.kind; logical_start <= x.lstart; sector_total <= x.total;
          volume_index <= x.vol; volume_start <= x.vstart;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= (hold_cnt == 0) && (rx_quiet || $urandom_range(99) >= 26);
    end
  end

  // Receiver hold-off counter, run on its own so the sender keeps offering.
  always @(posedge clk) begin
    if (hold_start) hold_cnt <= 300;
    else if (hold_cnt > 0) hold_cnt <= hold_cnt - 1;
  end

  // Monitor: records the input handshake and checks each result.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    accepted_flag <= in_valid && in_ready;
    if (!rst && out_valid && out_ready) begin
      run_t got, want;
      got = '{status, run_volume, run_sector, run_length, run_offset, volume_size, last};
      if (expected_runs.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected result %h", got);
      end else begin
        want = expected_runs.pop_front();
        if (got !== want) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("mismatch: expected %h, got %h", want, got);
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  function automatic xact_t seg_add(logic [47:0] ls, logic [47:0] len, logic [3:0] v,
                                    logic [47:0] ps);
    xact_t x;
    x.kind = 1'b0; x.lstart = ls; x.total = len; x.vol = v; x.vstart = ps;
    return x;
  endfunction

  function automatic xact_t req(logic [47:0] ls, logic [47:0] cnt);
    xact_t x;
    x.kind = 1'b1; x.lstart = ls; x.total = cnt;
    x.vol = 4'($urandom); x.vstart = 48'({$urandom, $urandom});
    return x;
  endfunction

  task automatic drain();
    while (pending.size() > 0 || in_valid || expected_runs.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_volumes(logic [4:0] v);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    attached = v;
  endtask

  // Random item over a table of small segments packed from a base.
  function automatic xact_t rand_item(logic [47:0] base);
    logic [47:0] ls;
    int r;
    r = $urandom_range(99);
    ls = base + 48'($urandom_range(400));
    if (r < 25) return seg_add(ls, 48'($urandom_range(60)), 4'($urandom),
                               48'({$urandom, $urandom}));
    if (r < 30) return req(ls, 48'd0);
    if (r < 33) return req(48'({$urandom, $urandom}), 48'({$urandom, $urandom}));
    return req(ls, 48'($urandom_range(1, 200)));
  endfunction

  initial begin
    logic [47:0] base;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    set_volumes(5'd0);

    // Directed part: gap on an empty table, empty request, bad volume.
    queue_item(req(48'd0, 48'd0));
    queue_item(req(48'd5, 48'd1));
    queue_item(seg_add(48'd0, 48'd100, 4'd0, 48'hFFFF_FFFF_FFF0));
    queue_item(req(48'd10, 48'd5));
    drain();
    set_volumes(5'd16);
    queue_item(seg_add(48'd100, 48'd0, 4'd15, 48'd7));
    queue_item(seg_add(48'd100, 48'd50, 4'd15, 48'h8000_0000_0000));
    queue_item(seg_add(48'd200, 48'd10, 4'd3, 48'd0));
    queue_item(seg_add(48'hFFFF_FFFF_FFFF, 48'd1, 4'd1, 48'd0));
    queue_item(seg_add(48'hFFFF_FFFF_FFF0, 48'hF, 4'd2, 48'd9));
    queue_item(seg_add(48'd0, 48'hFFFF_FFFF_FFFF, 4'd4, 48'd0));
    queue_item(req(48'd0, 48'd150));
    queue_item(req(48'd90, 48'd200));
    queue_item(req(48'hFFFF_FFFF_FFF0, 48'hFFFF_FFFF_FFFF));
    queue_item(req(48'd0, 48'hFFFF_FFFF_FFFF));
    drain();
    set_volumes(5'd31);
    queue_item(req(48'd95, 48'd20));
    drain();
    set_volumes(5'd3);
    queue_item(req(48'd95, 48'd20));
    queue_item(req(48'd205, 48'd3));
    drain();

    // Random part over several volume counts; the table fills up in the end.
    for (int ph = 0; ph < 5; ph++) begin
      base = 48'({$urandom, $urandom});
      base = base & 48'h7FFF_FFFF_FFFF;
      case (ph)
        0: set_volumes(5'd16);
        1: set_volumes(5'($urandom_range(1, 15)));
        2: set_volumes(5'd1);
        3: set_volumes(5'($urandom_range(17, 31)));
        default: set_volumes(5'd8);
      endcase
      if (ph == 1) tx_nogap = 1'b1;
      if (ph == 2) begin
        tx_nogap = 1'b0;
        rx_quiet = 1'b1;
      end
      if (ph == 3) rx_quiet = 1'b0;
      for (int i = 0; i < 46; i++) queue_item(rand_item(base));
      if (ph == 0) begin
        // Long receiver hold-off while the sender keeps offering.
        @(negedge clk);
        hold_start = 1'b1;
        @(negedge clk);
        hold_start = 1'b0;
        wait (hold_cnt == 0);
      end
      drain();
    end

    if (mismatches == 0 && expected_runs.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end
endmodule
